// File: sv/fsre_pkg.sv
package fsre_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam logic [7:0] FACTOR_RST = 8'd100;
    localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;
    localparam logic [31:0] GOLDEN_HALF = 32'h4F1B_BCDD;
    localparam logic [31:0] TURN_HALF   = 32'h8000_0000;
    localparam int DIV_BITS   = 30;
    localparam int DIV_PER    = 3;
    localparam int DIV_STAGES = DIV_BITS / DIV_PER;
    localparam int SQRT_STEPS = 31;

    typedef struct packed {
        logic              valid;
        logic              bad;
        logic [9:0]        count;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
        logic [15:0]       radius;
    } t_side;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/fibonacci_sphere_ray_endpoint.sv
// o_valid marks the result beat for each start taken
// throughput: one item per cycle, busy is always low; receiver cannot stall
// latency is set by the 10-stage divider and the 31-stage square root in series
// reset (synchronous, active low) clears all valid bits and loads r_factor with 100
module fibonacci_sphere_ray_endpoint #(
    parameter int CORDIC_STEPS = fsre_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic [9:0]         i_point_index,
    input  logic signed [15:0] i_origin_x,
    input  logic signed [15:0] i_origin_y,
    input  logic signed [15:0] i_origin_z,
    input  logic [15:0]        i_sphere_radius,
    output logic               o_valid,
    output logic signed [15:0] o_end_x,
    output logic signed [15:0] o_end_y,
    output logic signed [15:0] o_end_z,
    output logic [9:0]         o_point_count,
    output logic               o_index_bad
);

    localparam int STEPS = (CORDIC_STEPS < fsre_pkg::ATAN_ENTRIES) ?
                           CORDIC_STEPS : fsre_pkg::ATAN_ENTRIES;
    localparam int DLAT  = fsre_pkg::DIV_STAGES + 1;
    localparam int ZLAT  = DLAT + fsre_pkg::SQRT_STEPS + 2;
    localparam int CLAT  = STEPS + 2;
    localparam int LAT   = ZLAT + 6;
    localparam int SW    = $bits(fsre_pkg::t_side);

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        logic signed [15:0] r;
        if (v > 21'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -21'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic [7:0] r_factor;

    logic               r_a_vld;
    logic [9:0]         r_a_idx;
    logic signed [15:0] r_a_ox, r_a_oy, r_a_oz;
    logic [15:0]        r_a_rad;

    logic               r_b_vld;
    logic [9:0]         r_b_idx;
    logic signed [15:0] r_b_ox, r_b_oy, r_b_oz;
    logic [15:0]        r_b_rad;
    logic [9:0]         r_b_cnt;
    logic [31:0]        r_b_turns;
    logic [9:0]         n_b_cnt;
    logic [31:0]        n_b_turns;

    fsre_pkg::t_side    r_c_side;
    logic [10:0]        r_c_rem0;
    logic               r_c_neg;
    logic [31:0]        r_c_turns;
    logic signed [11:0] n_num;
    logic [11:0]        n_abs;

    logic signed [30:0] div_z;
    logic [29:0]        div_mag;
    logic [30:0]        sq_root;
    logic signed [32:0] cd_cos, cd_sin;
    logic [65:0]        cs_dly;
    logic [30:0]        z_dly;
    logic [SW-1:0]      side_dly;
    fsre_pkg::t_side    side_q;

    fsre_pkg::t_side    r_m1_side;
    logic signed [64:0] r_m1_pc, r_m1_ps;
    logic signed [30:0] r_m1_z;

    fsre_pkg::t_side    r_m2_side;
    logic signed [51:0] r_m2_px, r_m2_py, r_m2_pz;

    logic               r_vld;
    logic signed [15:0] r_ex, r_ey, r_ez;
    logic [9:0]         r_cnt;
    logic               r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= fsre_pkg::FACTOR_RST;
        end else if (i_cfg_we) begin
            r_factor <= i_cfg_data;
        end
    end

    // input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start;
        end
        r_a_idx <= i_point_index;
        r_a_ox  <= i_origin_x;
        r_a_oy  <= i_origin_y;
        r_a_oz  <= i_origin_z;
        r_a_rad <= i_sphere_radius;
    end

    // point count and golden-angle turns
    assign n_b_cnt   = 10'(r_factor) + 10'((24'(r_factor) * 24'(r_a_rad)) >> 15);
    assign n_b_turns = fsre_pkg::TURN_HALF +
                       32'(32'({r_a_idx, 1'b1}) * fsre_pkg::GOLDEN_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_idx   <= r_a_idx;
        r_b_ox    <= r_a_ox;
        r_b_oy    <= r_a_oy;
        r_b_oz    <= r_a_oz;
        r_b_rad   <= r_a_rad;
        r_b_cnt   <= n_b_cnt;
        r_b_turns <= n_b_turns;
    end

    // numerator n - 2i - 1, split into sign and magnitude
    assign n_num = $signed({2'b00, r_b_cnt}) - $signed({1'b0, r_b_idx, 1'b1});
    assign n_abs = n_num[11] ? 12'(-n_num) : 12'(n_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side.valid <= 1'b0;
        end else begin
            r_c_side.valid <= r_b_vld;
        end
        r_c_side.bad    <= (r_b_idx >= r_b_cnt);
        r_c_side.count  <= r_b_cnt;
        r_c_side.ox     <= r_b_ox;
        r_c_side.oy     <= r_b_oy;
        r_c_side.oz     <= r_b_oz;
        r_c_side.radius <= r_b_rad;
        r_c_rem0        <= {n_abs[9:0], 1'b0};
        r_c_neg         <= n_num[11];
        r_c_turns       <= r_b_turns;
    end

    fsre_div u_div (
        .i_clk  (i_clk),
        .i_rem0 (r_c_rem0),
        .i_cnt  (r_c_side.count),
        .i_neg  (r_c_neg),
        .o_z    (div_z),
        .o_mag  (div_mag)
    );

    fsre_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_mag  (div_mag),
        .o_root (sq_root)
    );

    fsre_cordic #(.STEPS(STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_turns (r_c_turns),
        .o_cos   (cd_cos),
        .o_sin   (cd_sin)
    );

    fsre_delay #(.W(66), .DEPTH(ZLAT - CLAT)) u_cs_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     ({cd_cos, cd_sin}),
        .o_q     (cs_dly)
    );

    fsre_delay #(.W(31), .DEPTH(ZLAT - DLAT)) u_z_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (div_z),
        .o_q     (z_dly)
    );

    fsre_delay #(.W(SW), .DEPTH(ZLAT)) u_side_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r_c_side),
        .o_q     (side_dly)
    );

    assign side_q = fsre_pkg::t_side'(side_dly);

    // direction times sin(phi)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_side.valid <= 1'b0;
        end else begin
            r_m1_side.valid <= side_q.valid;
        end
        r_m1_side.bad    <= side_q.bad;
        r_m1_side.count  <= side_q.count;
        r_m1_side.ox     <= side_q.ox;
        r_m1_side.oy     <= side_q.oy;
        r_m1_side.oz     <= side_q.oz;
        r_m1_side.radius <= side_q.radius;
        r_m1_pc <= 65'($signed(cs_dly[65:33]) * $signed({1'b0, sq_root}));
        r_m1_ps <= 65'($signed(cs_dly[32:0]) * $signed({1'b0, sq_root}));
        r_m1_z  <= $signed(z_dly);
    end

    // scale by radius with half-up rounding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_side.valid <= 1'b0;
        end else begin
            r_m2_side.valid <= r_m1_side.valid;
        end
        r_m2_side.bad    <= r_m1_side.bad;
        r_m2_side.count  <= r_m1_side.count;
        r_m2_side.ox     <= r_m1_side.ox;
        r_m2_side.oy     <= r_m1_side.oy;
        r_m2_side.oz     <= r_m1_side.oz;
        r_m2_side.radius <= r_m1_side.radius;
        r_m2_px <= 52'($signed(r_m1_pc[64:30]) * $signed({1'b0, r_m1_side.radius}))
                   + 52'sh8000_0000;
        r_m2_py <= 52'($signed(r_m1_ps[64:30]) * $signed({1'b0, r_m1_side.radius}))
                   + 52'sh8000_0000;
        r_m2_pz <= 52'($signed(r_m1_z) * $signed({1'b0, r_m1_side.radius}))
                   + 52'sh8000_0000;
    end

    // add origin and saturate; a bad index returns the origin unchanged
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= r_m2_side.valid;
        end
        r_cnt <= r_m2_side.count;
        r_bad <= r_m2_side.bad;
        if (r_m2_side.bad) begin
            r_ex <= r_m2_side.ox;
            r_ey <= r_m2_side.oy;
            r_ez <= r_m2_side.oz;
        end else begin
            r_ex <= sat16(21'($signed(r_m2_px[51:32])) + 21'(r_m2_side.ox));
            r_ey <= sat16(21'($signed(r_m2_py[51:32])) + 21'(r_m2_side.oy));
            r_ez <= sat16(21'($signed(r_m2_pz[51:32])) + 21'(r_m2_side.oz));
        end
    end

    assign busy          = 1'b0;
    assign o_valid       = r_vld;
    assign o_end_x       = r_ex;
    assign o_end_y       = r_ey;
    assign o_end_z       = r_ez;
    assign o_point_count = r_cnt;
    assign o_index_bad   = r_bad;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result beat without matching start");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_index_bad) |-> (o_point_count != 10'd0))
        else $error("good index with zero point count");

    a_bad_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_bad) |-> (o_end_x == $past(i_origin_x, LAT)))
        else $error("bad index beat does not return origin");
`endif

endmodule

// File: sv/fsre_delay.sv
module fsre_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_tap[k] <= '0;
            end
        end else begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

// File: sv/fsre_div.sv
module fsre_div (
    input  logic               i_clk,
    input  logic [10:0]        i_rem0,
    input  logic [9:0]         i_cnt,
    input  logic               i_neg,
    output logic signed [30:0] o_z,
    output logic [29:0]        o_mag
);

    localparam int NS = fsre_pkg::DIV_STAGES;
    localparam int NB = fsre_pkg::DIV_BITS;
    localparam int NP = fsre_pkg::DIV_PER;

    logic [10:0] r_rem [NS];
    logic [29:0] r_q   [NS];
    logic [9:0]  r_cnt [NS];
    logic        r_neg [NS];
    logic signed [30:0] r_z;
    logic [29:0]        r_mag;

    for (genvar s = 0; s < NS; s++) begin : g_stg
        logic [10:0] c_rem;
        logic [29:0] c_q;
        logic [9:0]  c_cnt;
        logic        c_neg;
        logic [10:0] n_rem;
        logic [29:0] n_q;

        if (s == 0) begin : g_first
            assign c_rem = i_rem0;
            assign c_q   = '0;
            assign c_cnt = i_cnt;
            assign c_neg = i_neg;
        end else begin : g_next
            assign c_rem = r_rem[s-1];
            assign c_q   = r_q[s-1];
            assign c_cnt = r_cnt[s-1];
            assign c_neg = r_neg[s-1];
        end

        always_comb begin
            logic [11:0] t;
            logic [29:0] dl;
            logic [10:0] d;
            n_rem = c_rem;
            n_q   = c_q;
            dl    = 30'(c_cnt);
            d     = {c_cnt, 1'b0};
            for (int b = 0; b < NP; b++) begin
                t = {n_rem, dl[5'(NB - 1 - s * NP - b)]};
                if (t >= {1'b0, d}) begin
                    n_rem = 11'(t - {1'b0, d});
                    n_q   = {n_q[28:0], 1'b1};
                end else begin
                    n_rem = t[10:0];
                    n_q   = {n_q[28:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_q[s]   <= n_q;
            r_cnt[s] <= c_cnt;
            r_neg[s] <= c_neg;
        end
    end

    // sign applied after the magnitude division
    always_ff @(posedge i_clk) begin
        r_mag <= r_q[NS-1];
        if (r_neg[NS-1]) begin
            r_z <= -$signed({1'b0, r_q[NS-1]});
        end else begin
            r_z <= $signed({1'b0, r_q[NS-1]});
        end
    end

    assign o_z   = r_z;
    assign o_mag = r_mag;

endmodule

// File: sv/fsre_sqrt.sv
module fsre_sqrt (
    input  logic        i_clk,
    input  logic [29:0] i_mag,
    output logic [30:0] o_root
);

    localparam int NS = fsre_pkg::SQRT_STEPS;

    logic [59:0] r_sq;
    logic [61:0] r_rad;
    logic [32:0] r_rem  [NS];
    logic [30:0] r_root [NS];
    logic [61:0] r_rd   [NS];

    // one minus z squared, Q60
    always_ff @(posedge i_clk) begin
        r_sq  <= i_mag * i_mag;
        r_rad <= {2'b01, 60'b0} - {2'b00, r_sq};
    end

    for (genvar k = 0; k < NS; k++) begin : g_stg
        logic [32:0] c_rem;
        logic [30:0] c_root;
        logic [61:0] c_rd;
        logic [32:0] t;
        logic [32:0] trial;

        if (k == 0) begin : g_first
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_rd   = r_rad;
        end else begin : g_next
            assign c_rem  = r_rem[k-1];
            assign c_root = r_root[k-1];
            assign c_rd   = r_rd[k-1];
        end

        assign t     = {c_rem[30:0], c_rd[2*(NS-1-k)+1 -: 2]};
        assign trial = {c_root, 2'b01};

        always_ff @(posedge i_clk) begin
            r_rd[k] <= c_rd;
            if (t >= trial) begin
                r_rem[k]  <= t - trial;
                r_root[k] <= {c_root[29:0], 1'b1};
            end else begin
                r_rem[k]  <= t;
                r_root[k] <= {c_root[29:0], 1'b0};
            end
        end
    end

    assign o_root = r_root[NS-1];

endmodule

// File: sv/fsre_cordic.sv
module fsre_cordic #(
    parameter int STEPS = fsre_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic [31:0]        i_turns,
    output logic signed [32:0] o_cos,
    output logic signed [32:0] o_sin
);

    logic signed [32:0] r_x [STEPS+1];
    logic signed [32:0] r_y [STEPS+1];
    logic signed [32:0] r_a [STEPS+1];
    logic               r_flip [STEPS+1];
    logic signed [32:0] r_c;
    logic signed [32:0] r_s;
    logic signed [32:0] a_ext;

    assign a_ext = $signed({i_turns[31], i_turns});

    // fold into the right half plane
    always_ff @(posedge i_clk) begin
        r_x[0] <= fsre_pkg::GAIN_Q30;
        r_y[0] <= '0;
        if (a_ext > 33'sh0_4000_0000) begin
            r_a[0]    <= a_ext - 33'sh0_8000_0000;
            r_flip[0] <= 1'b1;
        end else if (a_ext < -33'sh0_4000_0000) begin
            r_a[0]    <= a_ext + 33'sh0_8000_0000;
            r_flip[0] <= 1'b1;
        end else begin
            r_a[0]    <= a_ext;
            r_flip[0] <= 1'b0;
        end
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_stg
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        logic signed [32:0] at;

        assign xs = r_x[s] >>> s;
        assign ys = r_y[s] >>> s;
        assign at = $signed({1'b0, fsre_pkg::atan_turn(5'(s))});

        always_ff @(posedge i_clk) begin
            r_flip[s+1] <= r_flip[s];
            if (!r_a[s][32]) begin
                r_x[s+1] <= r_x[s] - ys;
                r_y[s+1] <= r_y[s] + xs;
                r_a[s+1] <= r_a[s] - at;
            end else begin
                r_x[s+1] <= r_x[s] + ys;
                r_y[s+1] <= r_y[s] - xs;
                r_a[s+1] <= r_a[s] + at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_flip[STEPS]) begin
            r_c <= -r_x[STEPS];
            r_s <= -r_y[STEPS];
        end else begin
            r_c <= r_x[STEPS];
            r_s <= r_y[STEPS];
        end
    end

    assign o_cos = r_c;
    assign o_sin = r_s;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic signed [15:0] ez;
        logic [9:0]         count;
        logic               bad;
    } t_ray;

    typedef struct packed {
        logic [9:0]         idx;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
        logic [15:0]        rad;
        logic               known;
        t_ray               want;
    } t_dir_row;

    localparam int N_DIR = 14;
    localparam int N_PHASES = 7;
    localparam int RAND_PER_PHASE = 155;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    logic [7:0]         i_cfg_data = 8'd0;
    logic [9:0]         i_point_index = 10'd0;
    logic signed [15:0] i_origin_x = 16'sd0;
    logic signed [15:0] i_origin_y = 16'sd0;
    logic signed [15:0] i_origin_z = 16'sd0;
    logic [15:0]        i_sphere_radius = 16'd0;
    logic               o_valid;
    logic signed [15:0] o_end_x;
    logic signed [15:0] o_end_y;
    logic signed [15:0] o_end_z;
    logic [9:0]         o_point_count;
    logic               o_index_bad;

    t_ray    endpoint_q[$];
    logic [7:0] factor_now = fsre_pkg::FACTOR_RST;
    int      mismatches = 0;
    int      beats_in = 0;
    int      beats_out = 0;
    int      bad_seen = 0;
    longint  atan_tab [0:23] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

    fibonacci_sphere_ray_endpoint dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_point_index(i_point_index), .i_origin_x(i_origin_x),
        .i_origin_y(i_origin_y), .i_origin_z(i_origin_z),
        .i_sphere_radius(i_sphere_radius), .o_valid(o_valid),
        .o_end_x(o_end_x), .o_end_y(o_end_y), .o_end_z(o_end_z),
        .o_point_count(o_point_count), .o_index_bad(o_index_bad)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic signed [15:0] clamp_q14(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic longint ray_offset(longint u30, logic [15:0] rad);
        return (u30 * longint'({48'd0, rad}) + 64'sh8000_0000) >>> 32;
    endfunction

    function automatic t_ray ray_predict(logic [9:0] idx, logic signed [15:0] ox,
                                         logic signed [15:0] oy,
                                         logic signed [15:0] oz,
                                         logic [15:0] rad, logic [7:0] lf);
        t_ray r;
        longint n, num, z30, s30, x, y, a, xs, ys, li;
        longint unsigned zz, d, root, bitv;
        logic [31:0] k2, turns;
        bit flip;
        li = longint'({54'd0, idx});
        n = longint'({56'd0, lf}) + ((longint'({56'd0, lf}) * longint'({48'd0, rad})) >> 15);
        r.count = n[9:0];
        r.bad = li >= n;
        r.ex = ox;
        r.ey = oy;
        r.ez = oz;
        if (r.bad) return r;
        num = n - 2 * li - 1;
        z30 = (num * 64'sh8000_0000 + (num >= 0 ? n : -n)) / (2 * n);
        zz = z30 * z30;
        d = (zz < (64'd1 << 60)) ? (64'd1 << 60) - zz : 64'd0;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > d) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (d >= root + bitv) begin
                d = d - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        s30 = root;
        k2 = {21'd0, idx, 1'b1};
        turns = fsre_pkg::TURN_HALF + k2 * fsre_pkg::GOLDEN_HALF;
        a = longint'({32'd0, turns});
        if (a >= 64'sh8000_0000) a = a - 64'sh1_0000_0000;
        flip = 0;
        if (a > 64'sh4000_0000) begin
            a = a - 64'sh8000_0000;
            flip = 1;
        end else if (a < -64'sh4000_0000) begin
            a = a + 64'sh8000_0000;
            flip = 1;
        end
        x = fsre_pkg::GAIN_Q30;
        y = 0;
        for (int i = 0; i < fsre_pkg::CORDIC_STEPS_DEF && i < fsre_pkg::ATAN_ENTRIES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0) begin
                x = x - ys;
                y = y + xs;
                a = a - atan_tab[i];
            end else begin
                x = x + ys;
                y = y - xs;
                a = a + atan_tab[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        r.ex = clamp_q14(longint'(ox) + ray_offset((x * s30) >>> 30, rad));
        r.ey = clamp_q14(longint'(oy) + ray_offset((y * s30) >>> 30, rad));
        r.ez = clamp_q14(longint'(oz) + ray_offset(z30, rad));
        return r;
    endfunction

    // one request beat, then a random gap
    task automatic send_ray(logic [9:0] idx, logic signed [15:0] ox,
                            logic signed [15:0] oy, logic signed [15:0] oz,
                            logic [15:0] rad, bit known, t_ray want);
        int gap;
        t_ray exp_ray;
        @(negedge i_clk);
        start = 1'b1;
        i_point_index = idx;
        i_origin_x = ox;
        i_origin_y = oy;
        i_origin_z = oz;
        i_sphere_radius = rad;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        exp_ray = known ? want : ray_predict(idx, ox, oy, oz, rad, factor_now);
        endpoint_q.insert(endpoint_q.size(), exp_ray);
        beats_in++;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_pipe();
        while (endpoint_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_factor(logic [7:0] v);
        @(negedge i_clk);
        start = 1'b0;
        drain_pipe();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(posedge i_clk);
        factor_now = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic signed [15:0] rand_origin();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF - 16'($urandom_range(0, 40));
            1: return 16'sh8000 + 16'($urandom_range(0, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_ray got, want;
        if (o_valid) begin
            got = '{o_end_x, o_end_y, o_end_z, o_point_count, o_index_bad};
            beats_out++;
            if (o_index_bad) bad_seen++;
            if (endpoint_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: x=%0d y=%0d z=%0d n=%0d bad=%0b",
                             got.ex, got.ey, got.ez, got.count, got.bad);
            end else begin
                want = endpoint_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp x=%0d y=%0d z=%0d n=%0d bad=%0b",
                                 want.ex, want.ey, want.ez, want.count, want.bad);
                        $display("          got x=%0d y=%0d z=%0d n=%0d bad=%0b",
                                 got.ex, got.ey, got.ez, got.count, got.bad);
                    end
                end
            end
        end
    end

    initial begin
        t_dir_row dir_rows [0:N_DIR-1];
        t_ray none;
        logic [7:0] factors [0:N_PHASES-1];
        int n, idx;
        logic [15:0] rad;
        none = '0;
        // rows at the reset factor of 100
        dir_rows[0]  = '{10'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1,
                         t_ray'{16'sd0, 16'sd0, 16'sd0, 10'd100, 1'b0}};
        dir_rows[1]  = '{10'd1023, 16'sh7FFF, 16'sh8000, 16'sd0, 16'hFFFF, 1'b1,
                         t_ray'{16'sh7FFF, 16'sh8000, 16'sd0, 10'd299, 1'b1}};
        dir_rows[2]  = '{10'd99, 16'sd123, -16'sd456, 16'sd789, 16'd0, 1'b1,
                         t_ray'{16'sd123, -16'sd456, 16'sd789, 10'd100, 1'b0}};
        dir_rows[3]  = '{10'd100, -16'sd5, 16'sd6, -16'sd7, 16'd0, 1'b1,
                         t_ray'{-16'sd5, 16'sd6, -16'sd7, 10'd100, 1'b1}};
        dir_rows[4]  = '{10'd0, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 1'b0, none};
        dir_rows[5]  = '{10'd298, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 1'b0, none};
        dir_rows[6]  = '{10'd299, 16'sd1, 16'sd2, 16'sd3, 16'hFFFF, 1'b1,
                         t_ray'{16'sd1, 16'sd2, 16'sd3, 10'd299, 1'b1}};
        dir_rows[7]  = '{10'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b0, none};
        dir_rows[8]  = '{10'd298, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 1'b0, none};
        dir_rows[9]  = '{10'd150, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b0, none};
        dir_rows[10] = '{10'd37, 16'sh4000, -16'sh4000, 16'sd0, 16'h8000, 1'b0, none};
        dir_rows[11] = '{10'd199, 16'sd0, 16'sd0, 16'sd0, 16'h8000, 1'b0, none};
        dir_rows[12] = '{10'd512, 16'sh5555, 16'shAAAA, 16'sh5555, 16'h5555, 1'b0, none};
        dir_rows[13] = '{10'd3, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'hAAAA, 1'b0, none};
        factors = '{8'd100, 8'd1, 8'd255, 8'd0, 8'd37, 8'd200, 8'd100};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r])
            send_ray(dir_rows[r].idx, dir_rows[r].ox, dir_rows[r].oy, dir_rows[r].oz,
                     dir_rows[r].rad, dir_rows[r].known, dir_rows[r].want);

        for (int p = 0; p < N_PHASES; p++) begin
            write_factor(p == N_PHASES - 1 ? 8'($urandom_range(2, 254)) : factors[p]);
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                case ($urandom_range(0, 7))
                    0: rad = 16'd0;
                    1: rad = 16'hFFFF;
                    default: rad = 16'($urandom);
                endcase
                n = factor_now + ((int'(factor_now) * int'(rad)) >> 15);
                if (n > 0 && $urandom_range(0, 9) < 8)
                    idx = ($urandom_range(0, 5) == 0) ?
                          (($urandom_range(0, 1) == 0) ? 0 : n - 1) :
                          $urandom_range(0, n - 1);
                else
                    idx = $urandom_range(0, 1023);
                send_ray(10'(idx), rand_origin(), rand_origin(), rand_origin(), rad,
                         1'b0, none);
            end
        end
        @(negedge i_clk);
        start = 1'b0;
        drain_pipe();

        $display("%0d request beats, %0d result beats (%0d out of range)",
                 beats_in, beats_out, bad_seen);
        $display("over %0d factor settings", N_PHASES + 1);
        if (mismatches == 0 && endpoint_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, endpoint_q.size());
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("Verification failed");
        $finish;
    end

endmodule

// File: fibonacci_sphere_ray_endpoint.f
sv/fsre_pkg.sv
sv/fsre_delay.sv
sv/fsre_div.sv
sv/fsre_sqrt.sv
sv/fsre_cordic.sv
sv/fibonacci_sphere_ray_endpoint.sv
tb/tb.sv
